// ===== hw/rtl/plc_pkg.sv =====
// ----------------------------------------------------------------------------
// plc_pkg
// Shared types for the positional character list: command codes, result
// status codes, controller states, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package plc_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2,
        OP_DUMP   = 2'd3
    } plc_op_t;

    typedef enum logic [1:0] {
        ST_ELEM    = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_END     = 2'd3
    } plc_status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } plc_state_t;

    typedef struct packed {
        logic        ins;
        logic        del;
        logic        emit;
        plc_status_t st;
        logic        sel_idx;
        logic        last;
        logic        idx_clr;
        logic        idx_inc;
    } plc_cmd_t;

    typedef struct packed {
        logic ins_ok;
        logic acc_ok;
        logic full;
        logic idx_end;
    } plc_flags_t;

endpackage

// ===== hw/rtl/plc_ctrl.sv =====
// ----------------------------------------------------------------------------
// plc_ctrl
// Controller: decodes each accepted item and sequences the dump.
// ----------------------------------------------------------------------------
module plc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        cmd,
    input  plc_pkg::plc_flags_t flags,
    output plc_pkg::plc_cmd_t   ctl,
    output logic              busy
);
    import plc_pkg::*;

    plc_state_t state_reg;
    plc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ctl         = '0;
        ctl.st      = ST_ELEM;
        busy        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (plc_op_t'(cmd))
                        OP_INSERT:
                        begin
                            if (!flags.ins_ok)
                            begin
                                ctl.emit = 1'b1;
                                ctl.st   = ST_INVALID;
                                ctl.last = 1'b1;
                            end
                            else if (flags.full)
                            begin
                                ctl.emit = 1'b1;
                                ctl.st   = ST_FULL;
                                ctl.last = 1'b1;
                            end
                            else
                            begin
                                ctl.ins = 1'b1;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (!flags.acc_ok)
                            begin
                                ctl.emit = 1'b1;
                                ctl.st   = ST_INVALID;
                                ctl.last = 1'b1;
                            end
                            else
                            begin
                                ctl.del = 1'b1;
                            end
                        end
                        OP_READ:
                        begin
                            ctl.emit = 1'b1;
                            ctl.last = 1'b1;
                            ctl.st   = flags.acc_ok ? ST_ELEM : ST_INVALID;
                        end
                        OP_DUMP:
                        begin
                            ctl.idx_clr = 1'b1;
                            state_next  = S_DUMP;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                busy        = 1'b1;
                ctl.emit    = 1'b1;
                ctl.sel_idx = 1'b1;
                if (flags.idx_end)
                begin
                    ctl.st     = ST_END;
                    ctl.last   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.idx_inc = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_dump_no_edit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |-> (!ctl.ins && !ctl.del))
        else $error("Edit issued during dump.");

    a_dump_exit_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP && ctl.last) |=> (state_reg == S_IDLE))
        else $error("Dump did not end after its end result.");

    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.ins, ctl.del, ctl.emit, ctl.idx_clr}))
        else $error("Conflicting controller commands.");

endmodule

// ===== hw/rtl/plc_dp.sv =====
// ----------------------------------------------------------------------------
// plc_dp
// Datapath: shifting element cells, length register, dump index, position
// checks, and the registered result outputs.
// ----------------------------------------------------------------------------
module plc_dp #(
    parameter int CAPACITY = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  plc_pkg::plc_cmd_t   ctl,
    input  logic [5:0]        position,
    input  logic [7:0]        item,
    output plc_pkg::plc_flags_t flags,
    output logic              strobe,
    output logic [1:0]        status,
    output logic [7:0]        value,
    output logic              last
);
    import plc_pkg::*;

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic [7:0]    cells_reg [CAPACITY];
    logic [7:0]    cells_next [CAPACITY];
    logic [LW-1:0] length_reg;
    logic [LW-1:0] length_next;
    logic [LW-1:0] idx_reg;
    logic [LW-1:0] idx_next;
    logic          strobe_reg;
    plc_status_t   status_reg;
    logic [7:0]    value_reg;
    logic          last_reg;

    logic [6:0]    pos7;
    logic [6:0]    len7;
    logic [IW-1:0] rd_addr;
    logic [7:0]    rd_data;

    assign pos7 = {1'b0, position};
    assign len7 = 7'(length_reg);

    assign flags.ins_ok  = (position != 6'd0) && (pos7 <= len7 + 7'd1);
    assign flags.acc_ok  = (position != 6'd0) && (pos7 <= len7);
    assign flags.full    = (length_reg == LW'(CAPACITY));
    assign flags.idx_end = (idx_reg == length_reg);

    always_comb
    begin
        for (int j = 0; j < CAPACITY; j++)
        begin
            cells_next[j] = cells_reg[j];
            if (ctl.ins)
            begin
                if (7'(j) + 7'd1 == pos7)
                begin
                    cells_next[j] = item;
                end
                else if (j > 0 && 7'(j) >= pos7)
                begin
                    cells_next[j] = cells_reg[(j > 0) ? j - 1 : 0];
                end
            end
            else if (ctl.del)
            begin
                if (j < CAPACITY - 1 && 7'(j) + 7'd1 >= pos7)
                begin
                    cells_next[j] = cells_reg[(j < CAPACITY - 1) ? j + 1 : j];
                end
            end
        end
    end

    always_comb
    begin
        length_next = length_reg;
        if (ctl.ins)
        begin
            length_next = length_reg + LW'(1);
        end
        else if (ctl.del)
        begin
            length_next = length_reg - LW'(1);
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (ctl.idx_clr)
        begin
            idx_next = '0;
        end
        else if (ctl.idx_inc)
        begin
            idx_next = idx_reg + LW'(1);
        end
    end

    assign rd_addr = ctl.sel_idx ? idx_reg[IW-1:0] : IW'(position - 6'd1);
    assign rd_data = cells_reg[rd_addr];

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < CAPACITY; j++)
        begin
            cells_reg[j] <= cells_next[j];
        end
        idx_reg <= idx_next;
        if (ctl.emit)
        begin
            status_reg <= ctl.st;
            value_reg  <= (ctl.st == ST_ELEM) ? rd_data : 8'd0;
            last_reg   <= ctl.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            length_reg <= length_next;
            strobe_reg <= ctl.emit;
        end
    end

    assign strobe = strobe_reg;
    assign status = status_reg;
    assign value  = value_reg;
    assign last   = last_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= LW'(CAPACITY))
        else $error("Length exceeds capacity.");

    a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ins |=> (length_reg == $past(length_reg) + LW'(1)))
        else $error("Insert did not grow the length.");

    a_nonelem_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && status_reg != ST_ELEM) |-> (value_reg == 8'd0 && last_reg))
        else $error("Status result with nonzero value or without last.");

endmodule

// ===== hw/rtl/positional_char_list.sv =====
// ----------------------------------------------------------------------------
// positional_char_list
// Ordered list of up to CAPACITY bytes addressed by 1-based position, with
// insert, delete, read and dump commands.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Insert, delete and
// read complete in the cycle they are taken; a result, if any, appears on
// the result ports with strobe high in the next cycle, and a new item may be
// given every cycle. A dump holds busy high while the dump index walks the
// cells, one element result per cycle followed by the end result, and no
// item is taken until busy falls again. Results cannot be stalled: the
// receiver must take each one in the cycle strobe is high.
module positional_char_list #(
    parameter int CAPACITY = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] cmd,
    input  logic [5:0] position,
    input  logic [7:0] item,
    output logic       strobe,
    output logic [1:0] status,
    output logic [7:0] value,
    output logic       last
);
    import plc_pkg::*;

    plc_cmd_t   ctl;
    plc_flags_t flags;

    plc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .flags (flags),
        .ctl   (ctl),
        .busy  (busy)
    );

    plc_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .position (position),
        .item     (item),
        .flags    (flags),
        .strobe   (strobe),
        .status   (status),
        .value    (value),
        .last     (last)
    );

endmodule

// ===== sim/positional_char_list_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_char_list_test
// Self-checking testbench for the positional character list. A short table
// of commands covers the extremes: empty and full store, position zero,
// out-of-range positions, head, middle and tail edits, and dumps. Random
// sequences of commands then grow and shrink the list towards changing
// targets. The sender works in bursts with random gaps. Every result is
// checked against a behavioral copy of the list kept in the testbench.
// ----------------------------------------------------------------------------
module positional_char_list_test;

    import plc_pkg::*;

    localparam int CAPACITY     = 32;
    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DROP_CYCLES  = 40;

    typedef struct packed {
        plc_status_t st;
        logic [7:0]  val;
        logic        fin;
    } list_result_t;

    typedef struct packed {
        plc_op_t     op;
        logic [5:0]  pos;
        logic [7:0]  data;
        logic [5:0]  reps;
        logic        typed;
        plc_status_t want;
    } stim_row_t;

    // Rows with typed set carry their single result in the row itself.
    localparam stim_row_t DIRECTED_ROWS [28] = '{
        '{OP_READ,   6'd1,  8'h00, 6'd1,  1'b1, ST_INVALID},
        '{OP_DELETE, 6'd1,  8'h00, 6'd1,  1'b1, ST_INVALID},
        '{OP_DUMP,   6'd0,  8'h00, 6'd1,  1'b1, ST_END},
        '{OP_INSERT, 6'd0,  8'hAA, 6'd1,  1'b1, ST_INVALID},
        '{OP_INSERT, 6'd2,  8'h55, 6'd1,  1'b1, ST_INVALID},
        '{OP_INSERT, 6'd1,  8'h00, 6'd1,  1'b0, ST_ELEM},
        '{OP_INSERT, 6'd2,  8'hFF, 6'd1,  1'b0, ST_ELEM},
        '{OP_INSERT, 6'd1,  8'h5A, 6'd1,  1'b0, ST_ELEM},
        '{OP_INSERT, 6'd2,  8'hA5, 6'd1,  1'b0, ST_ELEM},
        '{OP_READ,   6'd0,  8'h00, 6'd1,  1'b1, ST_INVALID},
        '{OP_READ,   6'd4,  8'h00, 6'd1,  1'b0, ST_ELEM},
        '{OP_READ,   6'd5,  8'h00, 6'd1,  1'b1, ST_INVALID},
        '{OP_DELETE, 6'd0,  8'h00, 6'd1,  1'b1, ST_INVALID},
        '{OP_DELETE, 6'd63, 8'h00, 6'd1,  1'b1, ST_INVALID},
        '{OP_DUMP,   6'd63, 8'hFF, 6'd1,  1'b0, ST_ELEM},
        '{OP_DELETE, 6'd2,  8'h00, 6'd1,  1'b0, ST_ELEM},
        '{OP_DELETE, 6'd3,  8'h00, 6'd1,  1'b0, ST_ELEM},
        '{OP_DELETE, 6'd1,  8'h00, 6'd1,  1'b0, ST_ELEM},
        '{OP_READ,   6'd1,  8'h00, 6'd1,  1'b0, ST_ELEM},
        '{OP_INSERT, 6'd2,  8'h11, 6'd31, 1'b0, ST_ELEM},
        '{OP_INSERT, 6'd34, 8'h77, 6'd1,  1'b1, ST_INVALID},
        '{OP_INSERT, 6'd33, 8'h77, 6'd1,  1'b1, ST_FULL},
        '{OP_INSERT, 6'd1,  8'h77, 6'd1,  1'b1, ST_FULL},
        '{OP_DUMP,   6'd0,  8'h00, 6'd1,  1'b0, ST_ELEM},
        '{OP_DELETE, 6'd32, 8'h00, 6'd1,  1'b0, ST_ELEM},
        '{OP_READ,   6'd32, 8'h00, 6'd1,  1'b1, ST_INVALID},
        '{OP_INSERT, 6'd32, 8'hC3, 6'd1,  1'b0, ST_ELEM},
        '{OP_READ,   6'd32, 8'h00, 6'd1,  1'b0, ST_ELEM}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  cmd;
    logic [5:0]  position;
    logic [7:0]  item;
    logic        strobe;
    logic [1:0]  status;
    logic [7:0]  value;
    logic        last;

    logic        typed_expect;
    plc_status_t typed_status;

    list_result_t expected_results [$];
    logic [7:0]   list_cells [CAPACITY];
    int unsigned  list_len;
    int unsigned  sender_len;
    int           queued_before;
    int           mismatches;
    int           cycles;

    positional_char_list #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .position (position),
        .item     (item),
        .strobe   (strobe),
        .status   (status),
        .value    (value),
        .last     (last)
    );

    always #5 clk = ~clk;

    task automatic push_result(input plc_status_t st, input logic [7:0] val, input logic fin);
        list_result_t r;
        r.st  = st;
        r.val = val;
        r.fin = fin;
        expected_results.push_back(r);
    endtask

    task automatic predict_command(input plc_op_t op, input logic [5:0] pos,
                                   input logic [7:0] data);
        int unsigned p;
        p = pos;
        case (op)
            OP_INSERT:
                if (p == 0 || p > list_len + 1)
                    push_result(ST_INVALID, 8'h00, 1'b1);
                else if (list_len >= CAPACITY)
                    push_result(ST_FULL, 8'h00, 1'b1);
                else
                begin
                    for (int i = int'(list_len); i >= int'(p); i--)
                        list_cells[i] = list_cells[i - 1];
                    list_cells[p - 1] = data;
                    list_len++;
                end
            OP_DELETE:
                if (p == 0 || p > list_len)
                    push_result(ST_INVALID, 8'h00, 1'b1);
                else
                begin
                    for (int i = int'(p); i < int'(list_len); i++)
                        list_cells[i - 1] = list_cells[i];
                    list_len--;
                end
            OP_READ:
                if (p == 0 || p > list_len)
                    push_result(ST_INVALID, 8'h00, 1'b1);
                else
                    push_result(ST_ELEM, list_cells[p - 1], 1'b1);
            default:
            begin
                for (int i = 0; i < int'(list_len); i++)
                    push_result(ST_ELEM, list_cells[i], 1'b0);
                push_result(ST_END, 8'h00, 1'b1);
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatches++;
        if (mismatches <= 50)
            $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("positional_char_list_test: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            queued_before = expected_results.size();
            predict_command(plc_op_t'(cmd), position, item);
            if (typed_expect)
            begin
                while (expected_results.size() > queued_before)
                    void'(expected_results.pop_back());
                push_result(typed_status, 8'h00, 1'b1);
            end
        end
        if (rst_n && strobe)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result, status", {6'd0, status}, 8'h00);
            else
            begin
                list_result_t want;
                want = expected_results.pop_front();
                if (status !== want.st)
                    report_mismatch("status", {6'd0, status}, {6'd0, want.st});
                if (value !== want.val)
                    report_mismatch("value", value, want.val);
                if (last !== want.fin)
                    report_mismatch("last", {7'd0, last}, {7'd0, want.fin});
            end
        end
    end

    task automatic send_item(input plc_op_t op, input logic [5:0] pos, input logic [7:0] data,
                             input logic typed, input plc_status_t want);
        start        <= 1'b1;
        cmd          <= op;
        position     <= pos;
        item         <= data;
        typed_expect <= typed;
        typed_status <= want;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (op == OP_INSERT && pos >= 1 && pos <= sender_len + 1 && sender_len < CAPACITY)
            sender_len++;
        else if (op == OP_DELETE && pos >= 1 && pos <= sender_len)
            sender_len--;
    endtask

    task automatic pause_sender(input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_for_drain();
        start <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [5:0] pick_position(input int hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return 6'd0;
        if (r < 12 && hi < 63)
            return 6'($urandom_range(hi + 1, 63));
        if (hi < 1)
            return 6'($urandom_range(0, 63));
        if (r < 20)
            return 6'(hi);
        if (r < 26)
            return 6'd1;
        return 6'($urandom_range(1, hi));
    endfunction

    initial
    begin
        int        burst_left;
        int        target;
        int        r;
        plc_op_t   op;
        logic [5:0] pos;

        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = OP_INSERT;
        position     = 6'd0;
        item         = 8'd0;
        typed_expect = 1'b0;
        typed_status = ST_ELEM;
        list_len     = 0;
        sender_len   = 0;
        mismatches   = 0;
        foreach (list_cells[i])
            list_cells[i] = 8'd0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[n])
        begin
            for (int k = 0; k < int'(DIRECTED_ROWS[n].reps); k++)
            begin
                send_item(DIRECTED_ROWS[n].op, DIRECTED_ROWS[n].pos,
                          8'(DIRECTED_ROWS[n].data + k * 37),
                          DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].want);
                if ($urandom_range(0, 3) == 0)
                    pause_sender($urandom_range(1, 4));
            end
        end
        wait_for_drain();

        burst_left = 0;
        target     = CAPACITY;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2 || $urandom_range(0, 99) == 0)
                wait_for_drain();
            if (burst_left == 0)
            begin
                pause_sender($urandom_range(0, 7));
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                         : $urandom_range(1, 12);
            end
            burst_left--;

            r = $urandom_range(0, 99);
            if (r < 7)
            begin
                op  = OP_DUMP;
                pos = 6'($urandom_range(0, 63));
            end
            else if (r < 30)
            begin
                op  = OP_READ;
                pos = pick_position(int'(sender_len));
            end
            else
            begin
                if (sender_len == target)
                begin
                    r = $urandom_range(0, 99);
                    target = (r < 25) ? CAPACITY : (r < 45) ? 0 : $urandom_range(0, CAPACITY);
                end
                if (sender_len < target)
                    op = OP_INSERT;
                else if (sender_len > target)
                    op = OP_DELETE;
                else
                    op = $urandom_range(0, 1) ? OP_INSERT : OP_DELETE;
                pos = (op == OP_INSERT) ? pick_position(int'(sender_len) + 1)
                                        : pick_position(int'(sender_len));
            end
            send_item(op, pos, 8'($urandom_range(0, 255)), 1'b0, ST_ELEM);
        end

        wait_for_drain();
        repeat (DROP_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("positional_char_list_test: PASS");
        else
            $display("positional_char_list_test: FAIL");
        $finish;
    end

endmodule
